@@ src/rffc_pkg.sv @@
// ----------------------------------------------------------------------------
// rffc_pkg: shared constants and types for the ring frame finder
// Ring geometry, frame layout offsets, sequencer states and the group count.
// ----------------------------------------------------------------------------
package rffc_pkg;

	localparam int Depth      = 64;
	localparam int AddrW      = $clog2(Depth);
	localparam int LenOffset  = 3;
	localparam int ExtraLen   = 4;
	localparam int IdOffset   = 1;
	localparam int ModeOffset = 2;
	localparam int ParamBytes = 4;
	localparam int GroupBytes = ParamBytes + 1;
	localparam int RawBytes   = (ParamBytes < 4) ? ParamBytes : 4;
	localparam int MaxResults = 50;
	localparam int LenW       = 9;
	localparam int CountW     = 6;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_HDR_RD,
		ST_HDR_CHK,
		ST_LEN_RD,
		ST_LEN_CHK,
		ST_SUM_RD,
		ST_SUM_ACC,
		ST_CHK,
		ST_OUT_RD,
		ST_OUT_ACC,
		ST_OUT_SEND,
		ST_WIPE
	} state_t;

	// Group count from the length byte: (L-1)/GroupBytes, saturated.
	function automatic logic [CountW-1:0] group_count(input logic [7:0] lbyte);
		logic [7:0] c;
		c = 8'd0;
		for (int v = 1; v < 256; v++) begin
			if (lbyte == 8'(v))
				c = 8'((v - 1) / GroupBytes);
		end
		if (c > 8'(MaxResults))
			c = 8'(MaxResults);
		return c[CountW-1:0];
	endfunction

endpackage

@@ src/rffc_ram.sv @@
// ----------------------------------------------------------------------------
// rffc_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module rffc_ram #(
	parameter int Width = 8,
	parameter int Entries = 64
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(Entries)-1:0] addr,
	input  logic [Width-1:0]           wdata,
	output logic [Width-1:0]           rdata
);

	logic [Width-1:0] mem_q [Entries];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end

endmodule

@@ src/ring_frame_finder_checksum.sv @@
// ----------------------------------------------------------------------------
// ring_frame_finder_checksum: header/length/checksum deframer over a byte ring
// Stores each word into a RAM ring, rescans it for a valid frame, emits groups.
// ----------------------------------------------------------------------------
// After reset a clearing pass zeroes every ring slot; no word is taken then.
// Each word is written, then up to 64 header slots are probed, each with a
// read and a compare; on a header hit the length and checksum bytes are read
// over the single RAM port, then each emitted group is gathered and sent, and
// the frame is wiped. Results wait on stall without loss.
module ring_frame_finder_checksum (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  robot_id,
	output logic [7:0]  mode_byte,
	output logic [5:0]  param_count,
	output logic [5:0]  param_index,
	output logic        param_valid,
	output logic [7:0]  param_position,
	output logic [31:0] param_raw,
	output logic        last_result
);
	import rffc_pkg::*;

	state_t state_q, state_d;
	logic [7:0]       header_q;
	logic [AddrW-1:0] wptr_q;
	logic [AddrW-1:0] h_q;       // header slot under test
	logic [AddrW:0]   sweep_q;   // clear pass counter
	logic [7:0]       byte_q;    // received word
	logic [7:0]       lbyte_q;
	logic [LenW-1:0]  len_q;
	logic [LenW-1:0]  k_q;       // frame byte offset
	logic [7:0]       sum_q;
	logic [7:0]       id_q, mode_q;
	logic [CountW-1:0] cnt_q, grp_q;
	logic [3:0]       gb_q;      // byte within group
	logic [7:0]       pos_q;
	logic [31:0]      raw_q;
	logic             ovalid_q;

	logic             ram_we;
	logic [AddrW-1:0] ram_addr;
	logic [7:0]       ram_wdata, ram_rdata;
	logic [LenW-1:0]  len_full;
	logic [LenW-1:0]  grp_base;
	logic [LenW-1:0]  rd_off;

	rffc_ram #(.Width(8), .Entries(Depth)) u_ring (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	assign len_full = LenW'(lbyte_q) + LenW'(ExtraLen);
	assign grp_base = LenW'(LenOffset + 1) + LenW'(grp_q) * LenW'(GroupBytes);
	assign rd_off   = grp_base + LenW'(gb_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:   if (sweep_q == (AddrW+1)'(Depth - 1)) state_d = ST_IDLE;
			ST_IDLE:    if (in_valid) state_d = ST_WRITE;
			ST_WRITE:   state_d = ST_HDR_RD;
			ST_HDR_RD:  state_d = ST_HDR_CHK;
			ST_HDR_CHK: begin
				if (ram_rdata == header_q)
					state_d = ST_LEN_RD;
				else if (h_q == AddrW'(Depth - 1))
					state_d = ST_IDLE;
				else
					state_d = ST_HDR_RD;
			end
			ST_LEN_RD:  state_d = ST_LEN_CHK;
			ST_LEN_CHK: state_d = ST_SUM_RD;
			ST_SUM_RD:  state_d = ST_SUM_ACC;
			ST_SUM_ACC: state_d = (k_q == len_q - 1'b1) ? ST_CHK : ST_SUM_RD;
			ST_CHK: begin
				if (8'(8'hFF - sum_q) == ram_rdata)
					state_d = ST_OUT_RD;
				else if (h_q == AddrW'(Depth - 1))
					state_d = ST_IDLE;
				else
					state_d = ST_HDR_RD;
			end
			ST_OUT_RD:  state_d = ST_OUT_ACC;
			ST_OUT_ACC: state_d = (gb_q == 4'(ParamBytes)) ? ST_OUT_SEND : ST_OUT_RD;
			ST_OUT_SEND: begin
				if (!ovalid_q || !out_stall) begin
					if (grp_q + 1'b1 >= cnt_q)
						state_d = ST_WIPE;
					else
						state_d = ST_OUT_RD;
				end
			end
			ST_WIPE:    if (k_q == len_q - 1'b1) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// RAM port and handshake.
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = h_q;
		ram_wdata = 8'd0;
		case (state_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = sweep_q[AddrW-1:0];
			end
			ST_WRITE: begin
				ram_we    = 1'b1;
				ram_addr  = wptr_q;
				ram_wdata = byte_q;
			end
			ST_HDR_RD: ram_addr = h_q;
			ST_LEN_RD: ram_addr = h_q + AddrW'(LenOffset);
			ST_LEN_CHK, ST_SUM_RD, ST_SUM_ACC: ram_addr = h_q + k_q[AddrW-1:0];
			ST_OUT_RD:  ram_addr = h_q + rd_off[AddrW-1:0];
			ST_WIPE: begin
				ram_we   = 1'b1;
				ram_addr = h_q + k_q[AddrW-1:0];
			end
			default: ram_addr = h_q;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			header_q <= 8'd0;
			wptr_q   <= '0;
			sweep_q  <= '0;
			h_q      <= '0;
			ovalid_q <= 1'b0;
			k_q      <= '0;
			grp_q    <= '0;
			gb_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				header_q <= cfg_wdata;
			if (ovalid_q && !out_stall && state_q != ST_OUT_SEND)
				ovalid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: sweep_q <= sweep_q + 1'b1;
				ST_IDLE: begin
					if (in_valid)
						byte_q <= rx_byte;
				end
				ST_WRITE: begin
					wptr_q <= wptr_q + 1'b1;
					h_q    <= '0;
				end
				ST_HDR_CHK: begin
					if (ram_rdata != header_q)
						h_q <= h_q + 1'b1;
				end
				ST_LEN_CHK: begin
					lbyte_q <= ram_rdata;
					len_q   <= LenW'(ram_rdata) + LenW'(ExtraLen);
					k_q     <= LenW'(1);
					sum_q   <= 8'd0;
				end
				ST_SUM_ACC: begin
					// The byte at offset len-1 is the check byte, kept in rdata.
					if (k_q != len_q - 1'b1) begin
						sum_q <= sum_q + ram_rdata;
						k_q   <= k_q + 1'b1;
					end
				end
				ST_CHK: begin
					cnt_q <= group_count(lbyte_q);
					grp_q <= '0;
					gb_q  <= 4'(IdOffset == 0 ? 0 : 0);
					k_q   <= '0;
					raw_q <= 32'd0;
					if (8'(8'hFF - sum_q) != ram_rdata)
						h_q <= h_q + 1'b1;
				end
				default: ;
			endcase
			// Output gather reads the position and raw bytes of a group.
			if (state_q == ST_OUT_ACC) begin
				if (gb_q == 4'd0)
					pos_q <= ram_rdata;
				else if (gb_q <= 4'(RawBytes))
					raw_q[8*(gb_q-4'd1) +: 8] <= ram_rdata;
				gb_q <= gb_q + 1'b1;
			end
			if (state_q == ST_OUT_SEND && (!ovalid_q || !out_stall)) begin
				ovalid_q  <= 1'b1;
				gb_q      <= '0;
				grp_q     <= grp_q + 1'b1;
				robot_id  <= id_q;
				mode_byte <= mode_q;
				param_count    <= cnt_q;
				param_index    <= (cnt_q != '0) ? grp_q : '0;
				param_valid    <= (cnt_q != '0);
				param_position <= (cnt_q != '0) ? pos_q : 8'd0;
				param_raw      <= (cnt_q != '0) ? raw_q : 32'd0;
				last_result    <= (grp_q + 1'b1 >= cnt_q);
				k_q <= '0;
			end
			if (state_q == ST_WIPE)
				k_q <= k_q + 1'b1;
		end
	end

	// Id and mode are taken during the checksum pass as the bytes go by.
	always_ff @(posedge clk) begin
		if (state_q == ST_SUM_ACC) begin
			if (k_q == LenW'(IdOffset))
				id_q <= ram_rdata;
			if (k_q == LenW'(ModeOffset))
				mode_q <= ram_rdata;
		end
		if (state_q == ST_CHK) begin
			if (len_full <= LenW'(IdOffset))
				id_q <= 8'd0;
		end
	end

	assign out_valid = ovalid_q;

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for ring_frame_finder_checksum
// Builds framed byte streams, some clean, some broken and some wrapping the
// ring. Each accepted word runs through an in-bench ring model, and every
// result group is compared field by field against the model's queue.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rffc_pkg::*;

	typedef logic [7:0] ring_t [Depth];

	typedef struct {
		logic [7:0]  robot_id;
		logic [7:0]  mode_byte;
		logic [5:0]  param_count;
		logic [5:0]  param_index;
		logic        param_valid;
		logic [7:0]  param_position;
		logic [31:0] param_raw;
		logic        last_result;
	} group_t;

	localparam int WatchdogLimit = 200000;
	localparam int DrainCycles   = 34000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  robot_id;
	logic [7:0]  mode_byte;
	logic [5:0]  param_count;
	logic [5:0]  param_index;
	logic        param_valid;
	logic [7:0]  param_position;
	logic [31:0] param_raw;
	logic        last_result;

	ring_t      ring_copy;
	int         wr_ptr;
	logic [7:0] header_copy;
	group_t     groups_due[$];
	int         error_count;
	int         idle_cycles;
	int         long_hold;
	int         stall_left;
	bit         no_gaps;
	bit         no_stalls;

	ring_frame_finder_checksum DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.robot_id(robot_id),
		.mode_byte(mode_byte),
		.param_count(param_count),
		.param_index(param_index),
		.param_valid(param_valid),
		.param_position(param_position),
		.param_raw(param_raw),
		.last_result(last_result)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic bit checksum_ok(input ring_t img, input int h, input int len);
		logic [7:0] sum;
		sum = 8'd0;
		for (int i = 1; i + 1 < len; i++)
			sum = sum + img[(h + i) % Depth];
		return (8'd255 - sum) == img[(h + len - 1) % Depth];
	endfunction

	// Model of one accepted word: store, rescan from slot 0, emit and wipe.
	function automatic void deframe_byte(input logic [7:0] b);
		int lb, len, cnt, nres, base;
		logic [31:0] raw;
		group_t g;
		ring_copy[wr_ptr] = b;
		wr_ptr = (wr_ptr + 1) % Depth;
		for (int h = 0; h < Depth; h++) begin
			if (ring_copy[h] != header_copy)
				continue;
			lb = ring_copy[(h + LenOffset) % Depth];
			len = lb + ExtraLen;
			if (!checksum_ok(ring_copy, h, len))
				continue;
			cnt = (lb == 0) ? 0 : (lb - 1) / GroupBytes;
			if (cnt > MaxResults)
				cnt = MaxResults;
			nres = (cnt == 0) ? 1 : cnt;
			for (int k = 0; k < nres; k++) begin
				g.robot_id = ring_copy[(h + IdOffset) % Depth];
				g.mode_byte = ring_copy[(h + ModeOffset) % Depth];
				g.param_count = 6'(cnt);
				g.param_index = (cnt != 0) ? 6'(k) : 6'd0;
				g.param_valid = (cnt != 0);
				g.param_position = 8'd0;
				raw = 32'd0;
				if (cnt != 0) begin
					base = LenOffset + 1 + k * GroupBytes;
					g.param_position = ring_copy[(h + base) % Depth];
					for (int i = 0; i < ParamBytes && i < 4; i++)
						raw |= 32'(ring_copy[(h + base + 1 + i) % Depth]) << (8 * i);
				end
				g.param_raw = raw;
				g.last_result = (k + 1 == nres);
				groups_due.push_back(g);
			end
			for (int i = 0; i < len; i++)
				ring_copy[(h + i) % Depth] = 8'd0;
			return;
		end
	endfunction

	// Frame image in frame coordinates; one free byte is solved for the checksum.
	function automatic void build_frame(input logic [7:0] hdr, input logic [7:0] lbyte,
			output ring_t img);
		int len, t;
		bit done;
		len = lbyte + ExtraLen;
		for (int i = 0; i < Depth; i++)
			img[i] = 8'($urandom);
		img[0] = hdr;
		img[LenOffset] = lbyte;
		done = 0;
		for (int c = 0; c < Depth && !done; c++) begin
			t = (c == 0) ? (len - 1) % Depth : c;
			if (t == 0 || t == LenOffset)
				continue;
			for (int x = 0; x < 256 && !done; x++) begin
				img[t] = 8'(x);
				done = checksum_ok(img, 0, len);
			end
		end
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int r, gap;
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		deframe_byte(b);
		r = $urandom_range(0, 99);
		gap = no_gaps ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) :
			$urandom_range(10, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame(input logic [7:0] lbyte, input bit broken);
		ring_t img;
		int len, nsend, idx;
		build_frame(header_copy, lbyte, img);
		len = lbyte + ExtraLen;
		nsend = (len > Depth) ? Depth : len;
		if (broken) begin
			idx = $urandom_range(1, nsend - 1);
			img[idx] ^= 8'(1 << $urandom_range(0, 7));
		end
		for (int i = 0; i < nsend; i++)
			send_byte(img[i]);
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		wait (groups_due.size() == 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_header(input logic [7:0] v);
		quiesce();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		header_copy = v;
	endtask

	function automatic logic [7:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return 8'($urandom_range(0, 4) * GroupBytes + 1 + $urandom_range(0, 1) * 2);
		else if (r < 90)
			return 8'($urandom_range(0, 60));
		return 8'($urandom_range(200, 255));
	endfunction

	task automatic test_reset_header();
		send_frame(8'd0, 0);
		send_byte(8'hFF);
		send_byte(8'h00);
	endtask

	task automatic test_directed();
		set_header(8'hFF);
		send_frame(8'd0, 0);
		send_frame(8'd11, 0);
		send_frame(8'd1, 1);
		send_frame(8'd255, 0);
	endtask

	task automatic test_random_stream(input int n_bytes);
		int sent, nsend;
		logic [7:0] lb;
		sent = 0;
		set_header(8'($urandom_range(1, 254)));
		while (sent < n_bytes) begin
			lb = pick_length();
			nsend = (int'(lb) + ExtraLen > Depth) ? Depth : int'(lb) + ExtraLen;
			if (sent + nsend > n_bytes) begin
				send_byte(8'($urandom));
				sent++;
			end else begin
				case ($urandom_range(0, 9))
					0: begin
						send_byte(8'($urandom));
						sent++;
					end
					1: begin
						send_frame(lb, 1);
						sent += nsend;
					end
					default: begin
						no_gaps = ($urandom_range(0, 4) == 0);
						send_frame(lb, 0);
						no_gaps = 0;
						sent += nsend;
					end
				endcase
			end
		end
	endtask

	task automatic test_backpressure();
		long_hold = 8000;
		send_frame(8'(2 * GroupBytes + 1), 0);
		for (int i = 0; i < 3; i++)
			send_byte(8'($urandom));
	endtask

	task automatic test_sender_pause();
		send_frame(8'(GroupBytes + 1), 0);
		in_valid <= 1'b0;
		wait (groups_due.size() == 0);
		@(posedge clk);
		no_stalls = 1;
		send_frame(8'd0, 0);
		no_stalls = 0;
	endtask

	// Result side: check each accepted word, then choose the next stall.
	always @(posedge clk) begin
		group_t g;
		if (out_valid && !out_stall) begin
			if (groups_due.size() == 0) begin
				$error("result word with nothing expected");
				error_count++;
			end else begin
				g = groups_due.pop_front();
				if (robot_id !== g.robot_id) begin
					$error("robot_id exp %0h got %0h", g.robot_id, robot_id);
					error_count++;
				end
				if (mode_byte !== g.mode_byte) begin
					$error("mode_byte exp %0h got %0h", g.mode_byte, mode_byte);
					error_count++;
				end
				if (param_count !== g.param_count) begin
					$error("param_count exp %0d got %0d", g.param_count, param_count);
					error_count++;
				end
				if (param_index !== g.param_index) begin
					$error("param_index exp %0d got %0d", g.param_index, param_index);
					error_count++;
				end
				if (param_valid !== g.param_valid) begin
					$error("param_valid exp %0b got %0b", g.param_valid, param_valid);
					error_count++;
				end
				if (param_position !== g.param_position) begin
					$error("param_position exp %0h got %0h", g.param_position,
						param_position);
					error_count++;
				end
				if (param_raw !== g.param_raw) begin
					$error("param_raw exp %0h got %0h", g.param_raw, param_raw);
					error_count++;
				end
				if (last_result !== g.last_result) begin
					$error("last_result exp %0b got %0b", g.last_result, last_result);
					error_count++;
				end
			end
		end
		if (long_hold > 0) begin
			stall_left = long_hold;
			long_hold = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (no_stalls || $urandom_range(0, 99) < 70) begin
			out_stall <= 1'b0;
		end else begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
				$urandom_range(0, 2);
			out_stall <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WatchdogLimit) begin
			$display("[ring_frame_finder_checksum] ERROR");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < Depth; i++)
			ring_copy[i] = 8'd0;
		wr_ptr = 0;
		header_copy = 8'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_header();
		test_directed();
		test_random_stream(24);
		test_backpressure();
		test_sender_pause();
		in_valid <= 1'b0;
		wait (groups_due.size() == 0);
		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0 && groups_due.size() == 0)
			$display("[ring_frame_finder_checksum] OK");
		else
			$display("[ring_frame_finder_checksum] ERROR");
		$finish;
	end

endmodule
